@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owm assertion failed");

// Next-cycle implication.
`define OWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owm assertion failed");

`endif

@@ hw/rtl/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// Types, codes and timing helpers of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int TIMER_WIDTH = 10;
    localparam int DUR_W       = 10;
    localparam int CMP_W       = (TIMER_WIDTH > DUR_W) ? TIMER_WIDTH : DUR_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY       = 3'd5;

    localparam logic [9:0] RESET_LOW_DEFAULT      = 10'd480;
    localparam logic [9:0] PRESENCE_WAIT_DEFAULT  = 10'd80;
    localparam logic [9:0] RESET_RECOVERY_DEFAULT = 10'd400;
    localparam logic [7:0] SLOT_DEFAULT           = 8'd60;
    localparam logic [3:0] START_LOW_DEFAULT      = 4'd1;
    localparam logic [3:0] RECOVERY_DEFAULT       = 4'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_RECOV = 4'd3,
        PH_W_LOW     = 4'd4,
        PH_W_REL     = 4'd5,
        PH_W_RECOV   = 4'd6,
        PH_R_LOW     = 4'd7,
        PH_R_REL     = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       line_level;
    } owm_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
    } owm_out_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_recovery_us;
        logic [7:0] slot_us;
        logic [3:0] start_low_us;
        logic [3:0] recovery_us;
    } owm_cfg_t;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // Clip a duration to what the tick counter can reach.
    function automatic logic [CMP_W-1:0] clip_dur(input logic [DUR_W-1:0] d);
        logic [CMP_W-1:0] d_ext;
        logic [CMP_W-1:0] t_max;
        d_ext = CMP_W'(d);
        t_max = CMP_W'(TIMER_MAX);
        return (d_ext > t_max) ? t_max : d_ext;
    endfunction

endpackage

@@ hw/rtl/owm_core.sv @@
// ----------------------------------------------------------------------------
// owm_core
// Phase sequencer of the bus master: one word per step, state held here.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owm_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  owm_pkg::owm_in_t  item,
    input  owm_pkg::owm_cfg_t cfg,
    output owm_pkg::owm_out_t result
);
    import owm_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   presence_reg, presence_next;
    logic [7:0]             read_reg, read_next;
    logic                   done;

    logic [7:0]             shift_s;
    logic [TIMER_WIDTH-1:0] cnt;
    logic [DUR_W-1:0]       len;
    logic                   cur_bit;
    logic                   expired;

    // Sample the read bit on the first released tick.
    always_comb
    begin
        shift_s = shift_reg;
        if (phase_reg == PH_R_REL && tick_reg == '0)
        begin
            shift_s[bit_reg] = shift_reg[bit_reg] | item.line_level;
        end
    end

    assign cur_bit = shift_reg[bit_reg];
    assign cnt     = (tick_reg == TIMER_MAX) ? tick_reg : tick_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:   len = cfg.reset_low_us;
            PH_RST_WAIT:  len = cfg.presence_wait_us;
            PH_RST_RECOV: len = cfg.reset_recovery_us;
            PH_W_LOW:     len = cur_bit ? DUR_W'(cfg.start_low_us) : DUR_W'(cfg.slot_us);
            PH_W_REL:     len = DUR_W'(cfg.slot_us);
            PH_W_RECOV:   len = DUR_W'(cfg.recovery_us);
            PH_R_LOW:     len = DUR_W'(cfg.start_low_us);
            PH_R_REL:     len = DUR_W'(cfg.slot_us);
            default:      len = '0;
        endcase
    end

    assign expired = !(CMP_W'(cnt) < clip_dur(len));

    // Next state.
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        read_next     = read_reg;
        done          = 1'b0;
        if (item.opcode != OP_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                tick_next = '0;
                bit_next  = '0;
                case (item.opcode)
                    OP_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    OP_WRITE:
                    begin
                        shift_next = item.data_byte;
                        phase_next = PH_W_LOW;
                    end
                    default:
                    begin
                        shift_next = '0;
                        phase_next = PH_R_LOW;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            shift_next = shift_s;
            if (!expired)
            begin
                tick_next = cnt;
            end
            else
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        presence_next = !item.line_level;
                        phase_next    = PH_RST_RECOV;
                    end
                    PH_RST_RECOV:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_W_LOW, PH_W_REL, PH_W_RECOV:
                    begin
                        if (phase_reg == PH_W_LOW && cur_bit)
                        begin
                            phase_next = PH_W_REL;
                        end
                        else if (phase_reg == PH_W_LOW && cfg.recovery_us != '0)
                        begin
                            phase_next = PH_W_RECOV;
                        end
                        else if (bit_reg == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:
                    begin
                        phase_next = PH_R_REL;
                    end
                    PH_R_REL:
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            read_next  = shift_s;
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done       = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_R_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Outputs, seen after this word.
    always_comb
    begin
        result.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW)
                        || (phase_next == PH_R_LOW);
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.presence  = presence_next;
        result.read_byte = read_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            read_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            read_reg     <= read_next;
        end
    end

    `OWM_ASSERT_NOW(a_done_goes_idle, step && result.done_res, !result.busy_res)
    `OWM_ASSERT_NOW(a_idle_bit_clear, phase_reg == PH_IDLE, bit_reg == '0 && tick_reg == '0)
    `OWM_ASSERT_NEXT(a_idle_tick_holds,
        step && phase_reg == PH_IDLE && item.opcode == OP_TICK,
        phase_reg == PH_IDLE && $stable(read_reg) && $stable(presence_reg))

endmodule

@@ hw/rtl/one_wire_bus_master_top.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// 1-Wire bus master timed by one-microsecond tick words. Each input word is a
// tick (carrying the sampled line level) or a command: bus reset with presence
// detect, write byte or read byte, both LSB first. Commands are taken only
// while idle; a command given while busy is ignored. Every input word yields
// exactly one result word carrying drive_low for the open-drain pad, busy,
// a done pulse, the last presence answer and the last byte read. Throughput is
// one word per clock unless out_ready stalls; the input and result registers
// sit around the single-pass phase sequencer. The user must write timing
// registers through the plain cfg port while the master is idle; the block
// does not enforce it. Write-0 slots get a released gap of recovery_us ticks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module one_wire_bus_master_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  owm_pkg::owm_in_t                    in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output owm_pkg::owm_out_t                   out_word,
    input  logic                                cfg_write,
    input  logic [owm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import owm_pkg::*;

    owm_cfg_t cfg_reg;

    logic     s1_valid_reg;
    owm_in_t  s1_item_reg;
    logic     out_valid_reg;
    owm_out_t out_word_reg;

    logic     advance;
    owm_out_t core_result;

    // Timing registers; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us      <= RESET_LOW_DEFAULT;
            cfg_reg.presence_wait_us  <= PRESENCE_WAIT_DEFAULT;
            cfg_reg.reset_recovery_us <= RESET_RECOVERY_DEFAULT;
            cfg_reg.slot_us           <= SLOT_DEFAULT;
            cfg_reg.start_low_us      <= START_LOW_DEFAULT;
            cfg_reg.recovery_us       <= RECOVERY_DEFAULT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RESET_LOW:      cfg_reg.reset_low_us      <= cfg_data;
                REG_PRESENCE_WAIT:  cfg_reg.presence_wait_us  <= cfg_data;
                REG_RESET_RECOVERY: cfg_reg.reset_recovery_us <= cfg_data;
                REG_SLOT:           cfg_reg.slot_us           <= cfg_data[7:0];
                REG_START_LOW:      cfg_reg.start_low_us      <= cfg_data[3:0];
                REG_RECOVERY:       cfg_reg.recovery_us       <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    // Advance the held word into the result register whenever that register
    // is empty or being drained this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    // Take a new word whenever the input register frees up this cycle.
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Payload holds without reset; load only on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_word;
        end
    end

    // Sequencer state moves only when the word leaves the input register.
    owm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `OWM_ASSERT_NOW(a_stall_means_full, !in_ready, s1_valid_reg && out_valid_reg)
    `OWM_ASSERT_NEXT(a_held_word_stays, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_item_reg))
    `OWM_ASSERT_NOW(a_low_only_busy, out_valid_reg && out_word_reg.drive_low,
        out_word_reg.busy_res)

endmodule

@@ verif/owm_checker.sv @@
// ----------------------------------------------------------------------------
// owm_checker
// Watches the word channels and the timing port of the 1-Wire bus master,
// tracks the bus sequencer on every accepted input word and checks each result
// word, in order, against the word the sequencer should give.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  owm_pkg::owm_in_t               in_word,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  owm_pkg::owm_out_t              out_word,
    input  logic                           cfg_write,
    input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             words_pending
);
    import owm_pkg::*;

    owm_cfg_t    timing;
    phase_t      bus_phase;
    logic [9:0]  ticks_in_phase;
    logic [2:0]  bit_pos;
    logic [7:0]  shift_byte;
    logic        device_present;
    logic [7:0]  last_read;
    owm_out_t    expected_words [$];
    owm_out_t    want;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("%0t: %s got %0h wanted %0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    function automatic logic [9:0] phase_length();
        case (bus_phase)
            PH_RST_LOW:   return timing.reset_low_us;
            PH_RST_WAIT:  return timing.presence_wait_us;
            PH_RST_RECOV: return timing.reset_recovery_us;
            PH_W_LOW:     return shift_byte[bit_pos] ? 10'(timing.start_low_us)
                                                     : 10'(timing.slot_us);
            PH_W_REL:     return 10'(timing.slot_us);
            PH_W_RECOV:   return 10'(timing.recovery_us);
            PH_R_LOW:     return 10'(timing.start_low_us);
            PH_R_REL:     return 10'(timing.slot_us);
            default:      return '0;
        endcase
    endfunction

    // Close the current bit slot; true when the byte is complete.
    function automatic logic close_bit(input logic reading);
        if (bit_pos == 3'd7) begin
            if (reading)
                last_read = shift_byte;
            bus_phase = PH_IDLE;
            bit_pos   = '0;
            return 1'b1;
        end
        bit_pos   = bit_pos + 3'd1;
        bus_phase = reading ? PH_R_LOW : PH_W_LOW;
        return 1'b0;
    endfunction

    function automatic logic advance_tick(input logic lvl);
        logic [9:0] cnt;
        logic       done;
        done = 1'b0;
        cnt  = ticks_in_phase;
        // read bit is the level on the first released tick
        if (bus_phase == PH_R_REL && ticks_in_phase == '0)
            shift_byte[bit_pos] = shift_byte[bit_pos] | lvl;
        // durations never exceed the counter range, so no clipping is needed
        if (cnt != TIMER_MAX)
            cnt = cnt + 10'd1;
        if (cnt < phase_length()) begin
            ticks_in_phase = cnt;
            return 1'b0;
        end
        ticks_in_phase = '0;
        case (bus_phase)
            PH_RST_LOW:   bus_phase = PH_RST_WAIT;
            PH_RST_WAIT:
            begin
                device_present = !lvl;
                bus_phase      = PH_RST_RECOV;
            end
            PH_RST_RECOV:
            begin
                bus_phase = PH_IDLE;
                done      = 1'b1;
            end
            PH_W_LOW:
            begin
                if (shift_byte[bit_pos])
                    bus_phase = PH_W_REL;
                else if (timing.recovery_us != '0)
                    bus_phase = PH_W_RECOV;
                else
                    done = close_bit(1'b0);
            end
            PH_W_REL, PH_W_RECOV: done = close_bit(1'b0);
            PH_R_LOW:             bus_phase = PH_R_REL;
            PH_R_REL:             done = close_bit(1'b1);
            default:              bus_phase = PH_IDLE;
        endcase
        return done;
    endfunction

    function automatic owm_out_t predict_master(input owm_in_t w);
        owm_out_t r;
        logic     done;
        done = 1'b0;
        if (w.opcode != OP_TICK) begin
            if (bus_phase == PH_IDLE) begin
                ticks_in_phase = '0;
                bit_pos        = '0;
                case (w.opcode)
                    OP_RESET: bus_phase = PH_RST_LOW;
                    OP_WRITE:
                    begin
                        shift_byte = w.data_byte;
                        bus_phase  = PH_W_LOW;
                    end
                    default:
                    begin
                        shift_byte = '0;
                        bus_phase  = PH_R_LOW;
                    end
                endcase
            end
        end
        else if (bus_phase != PH_IDLE) begin
            done = advance_tick(w.line_level);
        end
        r.drive_low = (bus_phase == PH_RST_LOW || bus_phase == PH_W_LOW ||
                       bus_phase == PH_R_LOW);
        r.busy_res  = (bus_phase != PH_IDLE);
        r.done_res  = done;
        r.presence  = device_present;
        r.read_byte = last_read;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timing         = '{RESET_LOW_DEFAULT, PRESENCE_WAIT_DEFAULT,
                               RESET_RECOVERY_DEFAULT, SLOT_DEFAULT,
                               START_LOW_DEFAULT, RECOVERY_DEFAULT};
            bus_phase      = PH_IDLE;
            ticks_in_phase = '0;
            bit_pos        = '0;
            shift_byte     = '0;
            device_present = 1'b0;
            last_read      = '0;
            mismatches     = 0;
            expected_words.delete();
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_RESET_LOW:      timing.reset_low_us      = cfg_data;
                    REG_PRESENCE_WAIT:  timing.presence_wait_us  = cfg_data;
                    REG_RESET_RECOVERY: timing.reset_recovery_us = cfg_data;
                    REG_SLOT:           timing.slot_us           = cfg_data[7:0];
                    REG_START_LOW:      timing.start_low_us      = cfg_data[3:0];
                    REG_RECOVERY:       timing.recovery_us       = cfg_data[3:0];
                    default:            ;
                endcase
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_master(in_word));
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", 8'h00, 8'h00);
                end
                else begin
                    want = expected_words.pop_front();
                    if (out_word.drive_low !== want.drive_low)
                        report_mismatch("drive_low", 8'(out_word.drive_low),
                                        8'(want.drive_low));
                    if (out_word.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 8'(out_word.busy_res),
                                        8'(want.busy_res));
                    if (out_word.done_res !== want.done_res)
                        report_mismatch("done_res", 8'(out_word.done_res),
                                        8'(want.done_res));
                    if (out_word.presence !== want.presence)
                        report_mismatch("presence", 8'(out_word.presence),
                                        8'(want.presence));
                    if (out_word.read_byte !== want.read_byte)
                        report_mismatch("read_byte", out_word.read_byte, want.read_byte);
                end
            end
        end
        words_pending <= expected_words.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 1-Wire bus master. Drives tick and command
// words with random gaps, random result back-pressure and several timing
// settings; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import owm_pkg::*;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    owm_in_t               in_word       = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    owm_out_t              out_word;
    logic                  cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_RESET_LOW;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    int                    mismatches;
    int                    words_pending;

    // Random gaps on both channels while this is set.
    logic                  stall_on      = 1'b1;
    int                    items_sent    = 0;
    // Timing the block is running with, used only to size tick bursts.
    owm_cfg_t              timing        = '{RESET_LOW_DEFAULT, PRESENCE_WAIT_DEFAULT,
                                             RESET_RECOVERY_DEFAULT, SLOT_DEFAULT,
                                             START_LOW_DEFAULT, RECOVERY_DEFAULT};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    one_wire_bus_master_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    owm_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    // Drop ready at random, with a chance of 11 in a hundred, while stalling is enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !(stall_on && $urandom_range(99) < 11);
    end

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // Ticks needed to carry an operation from its command to its done pulse.
    function automatic int op_ticks(input opcode_t op, input logic [7:0] d);
        int n;
        n = 0;
        case (op)
            OP_RESET: n = at_least_one(int'(timing.reset_low_us)) +
                          at_least_one(int'(timing.presence_wait_us)) +
                          at_least_one(int'(timing.reset_recovery_us));
            OP_WRITE:
            begin
                for (int b = 0; b < 8; b++) begin
                    if (d[b])
                        n += at_least_one(int'(timing.start_low_us)) +
                             at_least_one(int'(timing.slot_us));
                    else
                        n += at_least_one(int'(timing.slot_us)) +
                             int'(timing.recovery_us);
                end
            end
            OP_READ:  n = 8 * (at_least_one(int'(timing.start_low_us)) +
                               at_least_one(int'(timing.slot_us)));
            default:  n = 0;
        endcase
        return n;
    endfunction

    // Ticks that carry any operation, whatever its byte, to its end.
    function automatic int longest_op();
        int n;
        n = op_ticks(OP_RESET, 8'h00);
        if (op_ticks(OP_WRITE, 8'h00) > n)
            n = op_ticks(OP_WRITE, 8'h00);
        if (op_ticks(OP_WRITE, 8'hFF) > n)
            n = op_ticks(OP_WRITE, 8'hFF);
        if (op_ticks(OP_READ, 8'h00) > n)
            n = op_ticks(OP_READ, 8'h00);
        return n;
    endfunction

    // Present one word and hold it until accepted; returns right after the
    // accepting edge, so valid stays up if the next word follows at once.
    task automatic send_word(input opcode_t op, input logic [7:0] d, input logic lvl);
        owm_in_t w;
        w.opcode     = op;
        w.data_byte  = d;
        w.line_level = lvl;
        if (stall_on && $urandom_range(99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_word(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Command plus enough ticks to finish it, and a little slack.
    task automatic run_operation(input opcode_t op, input logic [7:0] d);
        send_word(op, d, 1'($urandom));
        run_ticks(op_ticks(op, d) + int'($urandom_range(0, 2)));
    endtask

    // Drop valid and hold off until every result word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
    endtask

    // Write all six timing registers on consecutive edges.
    task automatic load_timing(input owm_cfg_t c);
        logic [CFG_DATA_W-1:0] vals [6];
        logic [CFG_IDX_W-1:0]  regs [6];
        vals[0] = c.reset_low_us;
        vals[1] = c.presence_wait_us;
        vals[2] = c.reset_recovery_us;
        vals[3] = CFG_DATA_W'(c.slot_us);
        vals[4] = CFG_DATA_W'(c.start_low_us);
        vals[5] = CFG_DATA_W'(c.recovery_us);
        regs = '{REG_RESET_LOW, REG_PRESENCE_WAIT, REG_RESET_RECOVERY,
                 REG_SLOT, REG_START_LOW, REG_RECOVERY};
        for (int i = 0; i < 6; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        timing = c;
    endtask

    initial
    begin
        owm_cfg_t   c;
        opcode_t    op;
        logic [7:0] d;
        logic [7:0] pattern;
        int         len;
        int         phase_start;

        pattern = 8'h96;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: one full write.
        run_operation(OP_WRITE, 8'hA5);
        wait_drained();

        // Directed words with every register at zero: each phase lasts one
        // tick and the write-0 recovery gap is skipped.
        load_timing('0);
        send_word(OP_TICK, 8'hFF, 1'b0);        // tick while idle: no effect
        send_word(OP_RESET, 8'h5A, 1'b1);       // data and level ignored
        send_word(OP_TICK, 8'h00, 1'b1);        // end of reset low
        send_word(OP_TICK, 8'h00, 1'b0);        // presence sample: device answers
        send_word(OP_TICK, 8'h00, 1'b1);        // recovery, done
        send_word(OP_WRITE, 8'h00, 1'b1);
        for (int i = 0; i < 8; i++) begin
            if (i == 3)
                send_word(OP_READ, 8'hFF, 1'b0); // command while busy: ignored
            send_word(OP_TICK, 8'hFF, 1'b1);
        end
        send_word(OP_READ, 8'hFF, 1'b1);
        // Level on each low tick is the inverse, so only released ticks count.
        for (int i = 0; i < 16; i++)
            send_word(OP_TICK, 8'h00, i[0] ? pattern[i >> 1] : !pattern[i >> 1]);
        wait_drained();

        // Random traffic over several short timings; one phase runs without
        // any gaps or back-pressure.
        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                c = '{10'd1, 10'd1, 10'd1, 8'd1, 4'd1, 4'd0};
            end
            else begin
                c.reset_low_us      = 10'($urandom_range(0, 12));
                c.presence_wait_us  = 10'($urandom_range(0, 12));
                c.reset_recovery_us = 10'($urandom_range(0, 12));
                c.slot_us           = 8'($urandom_range(0, 10));
                c.start_low_us      = 4'($urandom_range(0, 15));
                c.recovery_us       = 4'($urandom_range(0, 15));
            end
            stall_on <= (p != 3);
            load_timing(c);
            phase_start = items_sent;
            while (items_sent - phase_start < 80) begin
                if ($urandom_range(99) < 75) begin
                    // Well-formed operation with random content; now and then
                    // cut it short so the next command lands on a busy master.
                    op  = opcode_t'($urandom_range(int'(OP_RESET), int'(OP_READ)));
                    d   = 8'($urandom);
                    len = op_ticks(op, d);
                    if ($urandom_range(9) == 0)
                        len = int'($urandom_range(0, len));
                    send_word(op, d, 1'($urandom));
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(39) == 0)
                            send_word(opcode_t'($urandom_range(int'(OP_RESET),
                                                               int'(OP_READ))),
                                      8'($urandom), 1'($urandom));
                        send_word(OP_TICK, 8'($urandom), 1'($urandom));
                    end
                    run_ticks(int'($urandom_range(0, 2)));
                end
                else begin
                    send_word(opcode_t'($urandom_range(int'(OP_TICK), int'(OP_READ))),
                              8'($urandom), 1'($urandom));
                end
            end
            // Advance far enough that any operation still running completes
            // before the timing registers change.
            run_ticks(longest_op());
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog: the full run needs well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
